// ===== src/prdm_pkg.sv =====
package prdm_pkg;

    // Input transaction fields, in the order of the interface description.
    typedef struct packed {
        logic        op;
        logic [15:0] now_us;
        logic        tag_present;
        logic [15:0] read_start_us;
        logic [15:0] read_end_us;
        logic        read_ok;
        logic [7:0]  read_length;
    } in_item_t;

    typedef struct packed {
        logic        armed;
        logic        read_due;
        logic        report;
        logic [23:0] read_time_sum;
        logic [23:0] cycle_time_sum;
        logic [15:0] read_time_min;
        logic [15:0] read_time_max;
        logic [15:0] cycle_time_min;
        logic [15:0] cycle_time_max;
        logic [7:0]  missed_deadlines;
        logic [7:0]  valid_frames;
        logic [7:0]  invalid_frames;
    } out_item_t;

    typedef struct packed {
        logic [14:0] interval_us;
        logic [14:0] slack_us;
        logic [7:0]  window_reads;
        logic [7:0]  payload_bytes;
    } cfg_t;

    typedef enum logic [1:0] {
        REG_INTERVAL,
        REG_SLACK,
        REG_WINDOW,
        REG_PAYLOAD
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic mark_fix;
        logic emit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } status_t;

    localparam logic OP_POLL      = 1'b0;
    localparam logic OP_READ_DONE = 1'b1;

    localparam logic [14:0] INTERVAL_RESET = 15'd10000;
    localparam logic [14:0] SLACK_RESET    = 15'd500;
    localparam logic [7:0]  WINDOW_RESET   = 8'd20;
    localparam logic [7:0]  PAYLOAD_RESET  = 8'd100;

    localparam int          PADDR_W = 4;
    localparam logic [15:0] MIN_CLEAR = 16'hFFFF;

endpackage

// ===== src/prdm_ctrl.sv =====
module prdm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  prdm_pkg::status_t  status,
    output prdm_pkg::cmd_t     cmd,
    output logic               busy
);

    prdm_pkg::state_t state_reg;
    prdm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prdm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            prdm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = prdm_pkg::ST_EVAL;
                end
            end
            prdm_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? prdm_pkg::ST_DIV : prdm_pkg::ST_OUT;
            end
            prdm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = prdm_pkg::ST_FINISH;
                end
            end
            prdm_pkg::ST_FINISH:
            begin
                cmd.mark_fix = 1'b1;
                state_next   = prdm_pkg::ST_OUT;
            end
            prdm_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = prdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prdm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/prdm_dp.sv =====
module prdm_dp #(
    parameter int TIMER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prdm_pkg::cmd_t      cmd,
    input  prdm_pkg::in_item_t  in_item,
    input  prdm_pkg::cfg_t      cfg,
    input  logic                out_stall,
    output prdm_pkg::status_t   status,
    output prdm_pkg::out_item_t out_item,
    output logic                out_valid
);

    localparam int CNT_W = $clog2(TIMER_BITS);

    // Scheduling and window state.
    logic                  active_reg,      active_next;
    logic [TIMER_BITS-1:0] cycle_mark_reg,  cycle_mark_next;
    logic [15:0]           last_cycle_reg,  last_cycle_next;
    logic [15:0]           read_min_reg,    read_min_next;
    logic [15:0]           read_max_reg,    read_max_next;
    logic [15:0]           cycle_min_reg,   cycle_min_next;
    logic [15:0]           cycle_max_reg,   cycle_max_next;
    logic [23:0]           read_sum_reg,    read_sum_next;
    logic [23:0]           cycle_sum_reg,   cycle_sum_next;
    logic [7:0]            reads_reg,       reads_next;
    logic [7:0]            missed_reg,      missed_next;
    logic [7:0]            valid_reg,       valid_next;
    logic [7:0]            invalid_reg,     invalid_next;
    logic                  out_valid_reg,   out_valid_next;

    // Working registers for one transaction.
    prdm_pkg::in_item_t    item_reg,        item_next;
    prdm_pkg::out_item_t   res_reg,         res_next;
    prdm_pkg::out_item_t   out_item_reg,    out_item_next;
    logic [TIMER_BITS-1:0] cyc_sh_reg,      cyc_sh_next;
    logic [15:0]           rem_reg,         rem_next;
    logic [CNT_W-1:0]      cnt_reg,         cnt_next;

    logic [TIMER_BITS-1:0] now_ext;
    logic [TIMER_BITS-1:0] cyc;
    logic                  cyc_ge;
    logic                  cyc_late;
    logic [15:0]           late_limit;
    logic [15:0]           dur;
    logic [15:0]           trial;
    logic [15:0]           intv16;

    assign now_ext    = TIMER_BITS'(item_reg.now_us);
    assign cyc        = now_ext - cycle_mark_reg;
    assign cyc_ge     = cyc >= TIMER_BITS'(cfg.interval_us);
    assign late_limit = 16'(cfg.interval_us) + 16'(cfg.slack_us);
    assign cyc_late   = cyc > TIMER_BITS'(late_limit);
    assign dur        = item_reg.read_end_us - item_reg.read_start_us;
    assign intv16     = 16'(cfg.interval_us);
    // The remainder stays below the interval, so its top bit is always clear.
    assign trial      = {rem_reg[14:0], cyc_sh_reg[TIMER_BITS-1]};

    assign status.need_div = (item_reg.op == prdm_pkg::OP_POLL) && active_reg
                             && item_reg.tag_present && cyc_ge
                             && (cfg.interval_us != '0);
    assign status.div_last = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_item  = out_item_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        logic [7:0] rw;

        active_next     = active_reg;
        cycle_mark_next = cycle_mark_reg;
        last_cycle_next = last_cycle_reg;
        read_min_next   = read_min_reg;
        read_max_next   = read_max_reg;
        cycle_min_next  = cycle_min_reg;
        cycle_max_next  = cycle_max_reg;
        read_sum_next   = read_sum_reg;
        cycle_sum_next  = cycle_sum_reg;
        reads_next      = reads_reg;
        missed_next     = missed_reg;
        valid_next      = valid_reg;
        invalid_next    = invalid_reg;
        out_valid_next  = out_valid_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        out_item_next   = out_item_reg;
        cyc_sh_next     = cyc_sh_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        rw              = reads_reg + 8'd1;

        if (cmd.load)
        begin
            item_next = in_item;
        end

        if (cmd.eval)
        begin
            res_next    = '0;
            cyc_sh_next = cyc;
            rem_next    = '0;
            cnt_next    = CNT_W'(TIMER_BITS - 1);
            if (item_reg.op == prdm_pkg::OP_POLL)
            begin
                if (!active_reg)
                begin
                    if (item_reg.tag_present)
                    begin
                        read_min_next   = prdm_pkg::MIN_CLEAR;
                        read_max_next   = '0;
                        cycle_min_next  = prdm_pkg::MIN_CLEAR;
                        cycle_max_next  = '0;
                        read_sum_next   = '0;
                        cycle_sum_next  = '0;
                        reads_next      = '0;
                        missed_next     = '0;
                        valid_next      = '0;
                        invalid_next    = '0;
                        last_cycle_next = '0;
                        cycle_mark_next = now_ext;
                        active_next     = 1'b1;
                    end
                end
                else if (!item_reg.tag_present)
                begin
                    active_next = 1'b0;
                end
                else if (cyc_ge)
                begin
                    res_next.read_due = 1'b1;
                    last_cycle_next   = cyc[15:0];
                    if (cyc[15:0] < cycle_min_reg)
                    begin
                        cycle_min_next = cyc[15:0];
                    end
                    if (cyc[15:0] > cycle_max_reg)
                    begin
                        cycle_max_next = cyc[15:0];
                    end
                    if (cyc_late)
                    begin
                        missed_next = missed_reg + 8'd1;
                    end
                    // With a nonzero interval the mark is fixed after the remainder.
                    if (cfg.interval_us == '0)
                    begin
                        cycle_mark_next = now_ext;
                    end
                end
            end
            else if (active_reg)
            begin
                if (dur < read_min_reg)
                begin
                    read_min_next = dur;
                end
                if (dur > read_max_reg)
                begin
                    read_max_next = dur;
                end
                if (!item_reg.read_ok)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    if (item_reg.read_length < cfg.payload_bytes)
                    begin
                        invalid_next = invalid_reg + 8'd1;
                    end
                    else
                    begin
                        valid_next = valid_reg + 8'd1;
                    end
                    reads_next     = rw;
                    read_sum_next  = read_sum_reg + 24'(dur);
                    cycle_sum_next = cycle_sum_reg + 24'(last_cycle_reg);
                    if (rw >= cfg.window_reads)
                    begin
                        res_next.report           = 1'b1;
                        res_next.read_time_sum    = read_sum_next;
                        res_next.cycle_time_sum   = cycle_sum_next;
                        res_next.read_time_min    = read_min_next;
                        res_next.read_time_max    = read_max_next;
                        res_next.cycle_time_min   = cycle_min_reg;
                        res_next.cycle_time_max   = cycle_max_reg;
                        res_next.missed_deadlines = missed_reg;
                        res_next.valid_frames     = valid_next;
                        res_next.invalid_frames   = invalid_next;
                        read_min_next  = prdm_pkg::MIN_CLEAR;
                        read_max_next  = '0;
                        cycle_min_next = prdm_pkg::MIN_CLEAR;
                        cycle_max_next = '0;
                        read_sum_next  = '0;
                        cycle_sum_next = '0;
                        reads_next     = '0;
                        missed_next    = '0;
                        valid_next     = '0;
                        invalid_next   = '0;
                    end
                end
            end
            res_next.armed = active_next;
        end

        // Restoring division, one quotient bit per cycle; only the remainder is kept.
        if (cmd.div_step)
        begin
            rem_next    = (trial >= intv16) ? (trial - intv16) : trial;
            cyc_sh_next = cyc_sh_reg << 1;
            cnt_next    = cnt_reg - CNT_W'(1);
        end

        if (cmd.mark_fix)
        begin
            cycle_mark_next = now_ext - TIMER_BITS'(rem_reg);
        end

        if (cmd.emit)
        begin
            out_item_next  = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cycle_mark_reg <= '0;
            last_cycle_reg <= '0;
            read_min_reg   <= prdm_pkg::MIN_CLEAR;
            read_max_reg   <= '0;
            cycle_min_reg  <= prdm_pkg::MIN_CLEAR;
            cycle_max_reg  <= '0;
            read_sum_reg   <= '0;
            cycle_sum_reg  <= '0;
            reads_reg      <= '0;
            missed_reg     <= '0;
            valid_reg      <= '0;
            invalid_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            cycle_mark_reg <= cycle_mark_next;
            last_cycle_reg <= last_cycle_next;
            read_min_reg   <= read_min_next;
            read_max_reg   <= read_max_next;
            cycle_min_reg  <= cycle_min_next;
            cycle_max_reg  <= cycle_max_next;
            read_sum_reg   <= read_sum_next;
            cycle_sum_reg  <= cycle_sum_next;
            reads_reg      <= reads_next;
            missed_reg     <= missed_next;
            valid_reg      <= valid_next;
            invalid_reg    <= invalid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
        cyc_sh_reg   <= cyc_sh_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
    end

endmodule

// ===== src/periodic_read_deadline_monitor.sv =====
// Flow: an item is loaded while idle and then evaluated; a poll that starts a read under a
// nonzero interval then passes through the remainder steps and the mark fix, and any other
// item goes straight to the output state, where its result is registered once the output is
// free. The block takes no new item until that result has been handed on, and the remainder
// unit resolves one bit of the elapsed time per cycle.
// Reset: rst_n is asynchronous and active low; it disarms the block, clears the window
// statistics and returns the configuration registers to their default values.
module periodic_read_deadline_monitor #(
    parameter int TIMER_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  prdm_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output prdm_pkg::out_item_t           out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prdm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    prdm_pkg::cfg_t     cfg_reg;
    prdm_pkg::cmd_t     cmd;
    prdm_pkg::status_t  status;
    prdm_pkg::reg_idx_t reg_idx;
    logic               busy;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = prdm_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_stall  = !rst_n || busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_us   <= prdm_pkg::INTERVAL_RESET;
            cfg_reg.slack_us      <= prdm_pkg::SLACK_RESET;
            cfg_reg.window_reads  <= prdm_pkg::WINDOW_RESET;
            cfg_reg.payload_bytes <= prdm_pkg::PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                prdm_pkg::REG_INTERVAL: cfg_reg.interval_us   <= pwdata[14:0];
                prdm_pkg::REG_SLACK:    cfg_reg.slack_us      <= pwdata[14:0];
                prdm_pkg::REG_WINDOW:   cfg_reg.window_reads  <= pwdata[7:0];
                prdm_pkg::REG_PAYLOAD:  cfg_reg.payload_bytes <= pwdata[7:0];
                default:                cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            prdm_pkg::REG_INTERVAL: prdata = 32'(cfg_reg.interval_us);
            prdm_pkg::REG_SLACK:    prdata = 32'(cfg_reg.slack_us);
            prdm_pkg::REG_WINDOW:   prdata = 32'(cfg_reg.window_reads);
            prdm_pkg::REG_PAYLOAD:  prdata = 32'(cfg_reg.payload_bytes);
            default:                prdata = '0;
        endcase
    end

    prdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    prdm_dp #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .out_stall (out_stall),
        .status    (status),
        .out_item  (out_item),
        .out_valid (out_valid)
    );

endmodule

// ===== src/prdm_checker.sv =====
module prdm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input prdm_pkg::out_item_t out_item
);

    // A held result must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Only one transaction is in flight, so an accepted item closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // A report comes only from a good read, which leaves the block armed.
    a_report_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.report |-> out_item.armed && !out_item.read_due)
        else $error("report without armed state");

    a_due_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.read_due |-> out_item.armed)
        else $error("read due while disarmed");

    // Statistics fields read zero unless a window is reported.
    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.report |->
            out_item.read_time_sum == '0 && out_item.cycle_time_sum == '0 &&
            out_item.read_time_min == '0 && out_item.read_time_max == '0 &&
            out_item.cycle_time_min == '0 && out_item.cycle_time_max == '0 &&
            out_item.missed_deadlines == '0 && out_item.valid_frames == '0 &&
            out_item.invalid_frames == '0)
        else $error("statistics present without report");

endmodule

bind periodic_read_deadline_monitor prdm_checker u_prdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
